### src/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
// No dependencies; included by the top-level file, which writes concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`define AST_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define AST_ALWAYS(lbl, clk, rstn, cond, msg)
`define AST_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

### src/ptrr_pkg.sv
// Package for the process table: operation and status codes, FSM state,
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package ptrr_pkg;
  localparam int SLOTS_DEF = 64;
  localparam logic [14:0] PID_LAST = 15'd32766;

  // Operation codes.
  localparam logic [3:0] OP_ALLOC = 4'd0;
  localparam logic [3:0] OP_FREE  = 4'd1;
  localparam logic [3:0] OP_READY = 4'd2;
  localparam logic [3:0] OP_YIELD = 4'd3;
  localparam logic [3:0] OP_BLOCK = 4'd4;
  localparam logic [3:0] OP_SCHED = 4'd5;
  localparam logic [3:0] OP_RUN   = 4'd6;
  localparam logic [3:0] OP_FORK  = 4'd7;
  localparam logic [3:0] OP_EXIT  = 4'd8;
  localparam logic [3:0] OP_FIND  = 4'd9;

  // Slot status codes.
  localparam logic [2:0] ST_UNUSED  = 3'd0;
  localparam logic [2:0] ST_UNINIT  = 3'd1;
  localparam logic [2:0] ST_READY   = 3'd2;
  localparam logic [2:0] ST_RUNNING = 3'd3;
  localparam logic [2:0] ST_BLOCKED = 3'd4;
  localparam logic [2:0] ST_ZOMBIE  = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MOD, S_SCAN, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_row;
    logic mod;
    logic scan_start;
    logic scan_run;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic needs_rmw;
    logic needs_scan;
    logic scan_done;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

### src/ptrr_ctrl.sv
// Controller state machine of the process table.
// Depends on ptrr_pkg for the state, command and status types.
`default_nettype none
module ptrr_ctrl
  import ptrr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: begin
        if (sts.needs_rmw) state_nxt = S_MOD;
        else if (sts.needs_scan) state_nxt = S_SCAN;
        else state_nxt = S_OUT;
      end
      S_MOD: begin
        state_nxt = sts.needs_scan ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_READ: begin
        cmd.rd_row = sts.needs_rmw;
        cmd.scan_start = !sts.needs_rmw && sts.needs_scan;
      end
      S_MOD: begin
        cmd.mod = 1'b1;
        cmd.scan_start = sts.needs_scan;
      end
      S_SCAN: cmd.scan_run = 1'b1;
      S_OUT: cmd.finish = sts.out_free;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

### src/ptrr_dp.sv
// Datapath of the process table: slot memories, scan counter, current slot,
// pid counter and the result register. Depends on ptrr_pkg.
`default_nettype none
module ptrr_dp
  import ptrr_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [3:0]         in_mode,
  input  wire logic [5:0]         in_slot,
  input  wire logic signed [31:0] in_exit_value,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_found,
  output logic [5:0]              out_result_slot,
  output logic [14:0]             out_result_pid,
  output logic signed [31:0]      out_result_exit,
  output logic                    out_parent_valid,
  output logic [5:0]              out_parent_slot,
  output logic [5:0]              out_current_slot
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = $clog2(SLOTS + 1);
  localparam int CW = $clog2(SLOTS + 1);

  // Slot memories; one valid bit per row stands for the reset contents.
  logic [2:0]        st_mem  [SLOTS];
  logic [14:0]       pid_mem [SLOTS];
  logic [PW-1:0]     par_mem [SLOTS];
  logic [31:0]       ex_mem  [SLOTS];
  logic [SLOTS-1:0]  vld_r;

  logic [3:0]        mode_r;
  logic [5:0]        slot_r;
  logic [31:0]       xval_r;
  logic [SW-1:0]     cur_r;
  logic [14:0]       pid_r;
  logic [CW-1:0]     cnt_r;
  logic [SW-1:0]     pos_r;
  logic              dv_r;
  logic [SW-1:0]     rd_addr_q;
  logic              rd_vld_q;
  logic [2:0]        rd_st_q;
  logic [14:0]       rd_pid_q;
  logic [PW-1:0]     rd_par_q;
  logic [31:0]       ex_q;

  logic              res_found_r;
  logic [5:0]        res_slot_r;
  logic [14:0]       res_pid_r;
  logic [31:0]       res_exit_r;
  logic              res_pv_r;
  logic [5:0]        res_ps_r;
  logic              out_valid_r;
  logic              o_found_r, o_pv_r;
  logic [5:0]        o_slot_r, o_ps_r, o_cur_r;
  logic [14:0]       o_pid_r;
  logic [31:0]       o_exit_r;

  logic [SW-1:0]     slot_idx, tgt, rd_addr, wa, pos_inc, cur_inc;
  logic [PW-1:0]     slot_p1, rd_par, wpar;
  logic [2:0]        rd_st, wst;
  logic [14:0]       rd_pid, wpid;
  logic [CW-1:0]     scan_n;
  logic              inrange, is_sched, match, hit, stop, issue, we, ex_we;

  assign slot_idx = SW'(slot_r);
  assign slot_p1  = PW'(slot_idx) + PW'(1);
  assign inrange  = int'(slot_r) < SLOTS;
  assign is_sched = (mode_r == OP_YIELD) || (mode_r == OP_BLOCK) || (mode_r == OP_SCHED);
  assign tgt      = ((mode_r == OP_YIELD) || (mode_r == OP_BLOCK)) ? cur_r : slot_idx;
  assign pos_inc  = (pos_r == SW'(SLOTS - 1)) ? '0 : pos_r + SW'(1);
  assign cur_inc  = (cur_r == SW'(SLOTS - 1)) ? '0 : cur_r + SW'(1);
  assign scan_n   = (mode_r == OP_ALLOC) ? CW'(SLOTS - 1) : CW'(SLOTS);

  // Row as read, with never-written rows showing their reset contents.
  assign rd_st  = rd_vld_q ? rd_st_q : ((rd_addr_q == '0) ? ST_RUNNING : ST_UNUSED);
  assign rd_pid = rd_vld_q ? rd_pid_q : '0;
  assign rd_par = rd_vld_q ? rd_par_q : '0;

  // Status to the controller: which operations need a row update and a scan,
  // when the scan is over, and whether the output register can take a beat.
  always_comb begin
    sts.needs_rmw = 1'b0;
    sts.needs_scan = 1'b0;
    sts.scan_done = stop || ((cnt_r == scan_n) && !dv_r);
    sts.out_free = !out_valid_r || out_ready;
    case (mode_r)
      OP_ALLOC, OP_SCHED: sts.needs_scan = 1'b1;
      OP_YIELD, OP_BLOCK: begin
        sts.needs_rmw = 1'b1;
        sts.needs_scan = 1'b1;
      end
      OP_FREE, OP_READY, OP_RUN, OP_FORK: sts.needs_rmw = inrange;
      OP_EXIT: begin
        sts.needs_rmw = inrange;
        sts.needs_scan = inrange;
      end
      OP_FIND: sts.needs_scan = inrange;
      default: begin
        sts.needs_rmw = 1'b0;
        sts.needs_scan = 1'b0;
      end
    endcase
  end

  // Scan match on the row that came back from memory.
  always_comb begin
    case (mode_r)
      OP_ALLOC: match = (rd_st == ST_UNUSED);
      OP_EXIT:  match = (rd_par == slot_p1);
      OP_FIND:  match = (rd_par == slot_p1) && (rd_st == ST_ZOMBIE);
      default:  match = (rd_st == ST_READY);
    endcase
  end

  assign hit   = cmd.scan_run && dv_r && match;
  assign stop  = hit && (mode_r != OP_EXIT);
  assign issue = cmd.rd_row || (cmd.scan_run && !stop && (cnt_r != scan_n));
  assign rd_addr = cmd.rd_row ? tgt : pos_r;

  // Write port: row update after a read, or the hit of a scan.
  always_comb begin
    we = 1'b0;
    ex_we = 1'b0;
    wa = rd_addr_q;
    wst = rd_st;
    wpid = rd_pid;
    wpar = rd_par;
    if (cmd.mod) begin
      we = 1'b1;
      case (mode_r)
        OP_FREE: wst = ST_UNUSED;
        OP_READY, OP_YIELD: wst = ST_READY;
        OP_BLOCK: wst = ST_BLOCKED;
        OP_RUN: wst = ST_RUNNING;
        OP_FORK: wpar = PW'(cur_r) + PW'(1);
        OP_EXIT: begin
          wst = ST_ZOMBIE;
          ex_we = 1'b1;
        end
        default: we = 1'b0;
      endcase
    end else if (hit) begin
      case (mode_r)
        OP_ALLOC: begin
          we = 1'b1;
          wst = ST_UNINIT;
          wpid = pid_r;
          wpar = '0;
        end
        OP_EXIT: begin
          we = 1'b1;
          wpar = '0;
        end
        OP_FIND: we = 1'b0;
        default: begin
          we = 1'b1;
          wst = ST_RUNNING;
        end
      endcase
    end
  end

  // Memory arrays: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      st_mem[wa] <= wst;
      pid_mem[wa] <= wpid;
      par_mem[wa] <= wpar;
    end
    if (ex_we) ex_mem[wa] <= xval_r;
    if (issue) begin
      rd_st_q <= st_mem[rd_addr];
      rd_pid_q <= pid_mem[rd_addr];
      rd_par_q <= par_mem[rd_addr];
      ex_q <= ex_mem[rd_addr];
      rd_vld_q <= vld_r[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Row valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  // Scan control, current slot and pid counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      pid_r <= 15'd1;
      dv_r <= 1'b0;
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      if (cmd.scan_start) begin
        cnt_r <= '0;
        dv_r <= 1'b0;
        if (mode_r == OP_ALLOC) pos_r <= SW'(1);
        else if (is_sched) pos_r <= cur_inc;
        else pos_r <= '0;
      end else if (cmd.scan_run) begin
        dv_r <= issue;
        if (issue) begin
          cnt_r <= cnt_r + CW'(1);
          pos_r <= pos_inc;
        end
      end
      if (cmd.mod && (mode_r == OP_RUN)) cur_r <= slot_idx;
      if (stop && is_sched) cur_r <= rd_addr_q;
      if (stop && (mode_r == OP_ALLOC)) begin
        pid_r <= (pid_r == PID_LAST) ? 15'd1 : pid_r + 15'd1;
      end
    end
  end

  // Item fields and result fields.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      slot_r <= in_slot;
      xval_r <= in_exit_value;
      res_found_r <= 1'b0;
      res_slot_r <= '0;
      res_pid_r <= '0;
      res_exit_r <= '0;
      res_pv_r <= 1'b0;
      res_ps_r <= '0;
    end
    if (cmd.mod && (mode_r == OP_EXIT) && (rd_par != '0) && (rd_par != slot_p1)) begin
      res_pv_r <= 1'b1;
      res_ps_r <= 6'(rd_par - PW'(1));
    end
    if (stop) begin
      res_found_r <= 1'b1;
      res_slot_r <= 6'(rd_addr_q);
      if (mode_r == OP_ALLOC) res_pid_r <= pid_r;
      if (mode_r == OP_FIND) begin
        res_pid_r <= rd_pid;
        res_exit_r <= ex_q;
      end
    end
  end

  // Output register: holds a finished beat while the next item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_found_r <= res_found_r;
      o_slot_r <= res_slot_r;
      o_pid_r <= res_pid_r;
      o_exit_r <= res_exit_r;
      o_pv_r <= res_pv_r;
      o_ps_r <= res_ps_r;
      o_cur_r <= 6'(cur_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = o_found_r;
  assign out_result_slot  = o_slot_r;
  assign out_result_pid   = o_pid_r;
  assign out_result_exit  = o_exit_r;
  assign out_parent_valid = o_pv_r;
  assign out_parent_slot  = o_ps_r;
  assign out_current_slot = o_cur_r;
endmodule
`default_nettype wire

### src/process_table_round_robin.sv
// Flow: an item is latched, then a slot update reads its row and writes it back;
// scanning operations walk the slot memory one entry per cycle through a
// registered read, and the result waits for a free output register.
// One item at a time: the next beat is taken in the cycle after the result is registered.
// Reset: synchronous active-low; slot 0 running and current, others unused,
// pid counter at 1. No clearing pass: per-row valid bits cover reset contents.
`default_nettype none
`include "assert_macros.svh"
module process_table_round_robin
  import ptrr_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         in_mode,
  input  wire logic [5:0]         in_slot,
  input  wire logic signed [31:0] in_exit_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_found,
  output logic [5:0]              out_result_slot,
  output logic [14:0]             out_result_pid,
  output logic signed [31:0]      out_result_exit,
  output logic                    out_parent_valid,
  output logic [5:0]              out_parent_slot,
  output logic [5:0]              out_current_slot
);
  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  ptrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, scan and result datapath.
  ptrr_dp #(.SLOTS(SLOTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_slot          (in_slot),
    .in_exit_value    (in_exit_value),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_result_slot  (out_result_slot),
    .out_result_pid   (out_result_pid),
    .out_result_exit  (out_result_exit),
    .out_parent_valid (out_parent_valid),
    .out_parent_slot  (out_parent_slot),
    .out_current_slot (out_current_slot)
  );

  // An accepted item keeps the input closed for at least the next cycle.
  `AST_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "input taken twice in a row")
  // A miss reports neither a slot nor a pid.
  `AST_ALWAYS(a_miss_zero, clk, rst_n, !(out_valid && !out_found) || (out_result_slot == 6'd0 && out_result_pid == 15'd0), "miss carries slot or pid")
  // A parent report comes only from exit, which never reports a found slot.
  `AST_ALWAYS(a_pv_excl, clk, rst_n, !(out_valid && out_parent_valid) || !out_found, "parent report with found slot")
endmodule
`default_nettype wire

### dv/ptrr_checker.sv
// Checker for the process table: watches both channels, predicts each result
// from its own copy of the table, and compares. Depends on ptrr_pkg.
`default_nettype none
module ptrr_checker
  import ptrr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [3:0]         in_mode,
  input  wire logic [5:0]         in_slot,
  input  wire logic signed [31:0] in_exit_value,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic               out_found,
  input  wire logic [5:0]         out_result_slot,
  input  wire logic [14:0]        out_result_pid,
  input  wire logic signed [31:0] out_result_exit,
  input  wire logic               out_parent_valid,
  input  wire logic [5:0]         out_parent_slot,
  input  wire logic [5:0]         out_current_slot,
  output int                      fail_count,
  output int                      pending
);
  localparam int N = SLOTS_DEF;

  typedef struct packed {
    logic        found;
    logic [5:0]  rslot;
    logic [14:0] pid;
    logic [31:0] xcode;
    logic        pvalid;
    logic [5:0]  pslot;
    logic [5:0]  cur;
  } answer_t;

  logic [2:0]  status_q [N];
  logic [14:0] pid_q    [N];
  logic [6:0]  parent_q [N];
  logic [31:0] xcode_q  [N];
  logic [5:0]  cur_q;
  logic [14:0] pid_ctr;
  answer_t     answers [$];

  // Round-robin pick: ring after the current slot, current slot last.
  function automatic answer_t pick_ready(answer_t a);
    int p;
    for (int k = 1; k <= N; k++) begin
      p = (cur_q + k) % N;
      if (status_q[p] == ST_READY) begin
        status_q[p] = ST_RUNNING;
        cur_q = 6'(p);
        a.found = 1'b1;
        a.rslot = 6'(p);
        return a;
      end
    end
    return a;
  endfunction

  function automatic answer_t apply_op(logic [3:0] op, logic [5:0] s, logic [31:0] xv);
    answer_t a;
    a = '0;
    case (op)
      OP_ALLOC: begin
        for (int i = 1; i < N; i++) begin
          if (status_q[i] == ST_UNUSED) begin
            pid_q[i] = pid_ctr;
            pid_ctr = (pid_ctr == PID_LAST) ? 15'd1 : pid_ctr + 15'd1;
            status_q[i] = ST_UNINIT;
            parent_q[i] = '0;
            a.found = 1'b1;
            a.rslot = 6'(i);
            a.pid = pid_q[i];
            break;
          end
        end
      end
      OP_FREE:  status_q[s] = ST_UNUSED;
      OP_READY: status_q[s] = ST_READY;
      OP_YIELD: begin
        status_q[cur_q] = ST_READY;
        a = pick_ready(a);
      end
      OP_BLOCK: begin
        status_q[cur_q] = ST_BLOCKED;
        a = pick_ready(a);
      end
      OP_SCHED: a = pick_ready(a);
      OP_RUN: begin
        status_q[s] = ST_RUNNING;
        cur_q = s;
      end
      OP_FORK: parent_q[s] = {1'b0, cur_q} + 7'd1;
      OP_EXIT: begin
        status_q[s] = ST_ZOMBIE;
        xcode_q[s] = xv;
        for (int i = 0; i < N; i++)
          if (parent_q[i] == {1'b0, s} + 7'd1) parent_q[i] = '0;
        if (parent_q[s] != 0) begin
          a.pvalid = 1'b1;
          a.pslot = 6'(parent_q[s] - 7'd1);
        end
      end
      OP_FIND: begin
        for (int i = 0; i < N; i++) begin
          if (parent_q[i] == {1'b0, s} + 7'd1 && status_q[i] == ST_ZOMBIE) begin
            a.found = 1'b1;
            a.rslot = 6'(i);
            a.pid = pid_q[i];
            a.xcode = xcode_q[i];
            break;
          end
        end
      end
      default: ;
    endcase
    a.cur = cur_q;
    return a;
  endfunction

  // Report one field mismatch.
  task automatic flag(string what, longint unsigned exp_v, longint unsigned act_v);
    $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
    fail_count++;
  endtask

  // Predict on every input beat and compare on every result beat.
  always @(posedge clk) begin
    answer_t e;
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        status_q[i] = ST_UNUSED;
        pid_q[i] = '0;
        parent_q[i] = '0;
        xcode_q[i] = '0;
      end
      status_q[0] = ST_RUNNING;
      cur_q = '0;
      pid_ctr = 15'd1;
      answers.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready)
        answers.push_back(apply_op(in_mode, in_slot, in_exit_value));
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual slot %0d",
                   $time, out_result_slot);
          fail_count++;
        end else begin
          e = answers.pop_front();
          if (out_found !== e.found) flag("found", e.found, out_found);
          if (out_result_slot !== e.rslot) flag("result_slot", e.rslot, out_result_slot);
          if (out_result_pid !== e.pid) flag("result_pid", e.pid, out_result_pid);
          if (out_result_exit !== e.xcode) flag("result_exit", e.xcode, out_result_exit);
          if (out_parent_valid !== e.pvalid) flag("parent_valid", e.pvalid, out_parent_valid);
          if (out_parent_slot !== e.pslot) flag("parent_slot", e.pslot, out_parent_slot);
          if (out_current_slot !== e.cur) flag("current_slot", e.cur, out_current_slot);
        end
      end
    end
    pending = answers.size();
  end
endmodule
`default_nettype wire

### dv/tb_process_table_round_robin.sv
// Testbench top for the process table: directed and random operation beats
// with bursty sending and stalled receiving. Depends on ptrr_pkg and ptrr_checker.
`default_nettype none
module tb_process_table_round_robin;
  import ptrr_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         in_mode;
  logic [5:0]         in_slot;
  logic signed [31:0] in_exit_value;
  logic               out_valid;
  logic               out_ready;
  logic               out_found;
  logic [5:0]         out_result_slot;
  logic [14:0]        out_result_pid;
  logic signed [31:0] out_result_exit;
  logic               out_parent_valid;
  logic [5:0]         out_parent_slot;
  logic [5:0]         out_current_slot;
  int                 fail_count;
  int                 pending;

  process_table_round_robin u_top (.*);

  ptrr_checker u_chk (.*);

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver stalls in a pattern of its own: quiet stretches and busy ones.
  initial begin
    int phase;
    out_ready <= 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if ((phase / 200) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) < 60);
    end
  end

  // Present one beat and hold it until it is accepted.
  task automatic send_op(logic [3:0] op, logic [5:0] s, logic [31:0] xv);
    in_valid <= 1'b1;
    in_mode <= op;
    in_slot <= s;
    in_exit_value <= xv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random operation: any of the ten operations, alloc often turned into ready, some unknown modes.
  task automatic random_op();
    logic [3:0] op;
    logic [5:0] s;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) op = 4'($urandom_range(10, 15));
    else op = 4'($urandom_range(0, 9));
    if (op == OP_ALLOC && $urandom_range(0, 1)) op = OP_READY;
    s = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 11));
    send_op(op, s, $urandom());
  endtask

  initial begin
    logic [3:0] ops [0:9];
    int burst;
    ops = '{OP_ALLOC, OP_FREE, OP_READY, OP_YIELD, OP_BLOCK,
            OP_SCHED, OP_RUN, OP_FORK, OP_EXIT, OP_FIND};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= '0;
    in_slot <= '0;
    in_exit_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each operation, extremes, self parent, unknown mode.
    send_op(OP_SCHED, 6'd0, 32'd0);
    send_op(OP_ALLOC, 6'd0, 32'd0);
    send_op(OP_ALLOC, 6'd0, 32'd0);
    send_op(OP_FORK, 6'd1, 32'd0);
    send_op(OP_FORK, 6'd0, 32'd0);
    send_op(OP_READY, 6'd2, 32'd0);
    send_op(OP_YIELD, 6'd0, 32'd0);
    send_op(OP_EXIT, 6'd1, 32'h8000_0000);
    send_op(OP_FIND, 6'd0, 32'd0);
    send_op(OP_EXIT, 6'd0, 32'h7FFF_FFFF);
    send_op(OP_RUN, 6'd63, 32'hFFFF_FFFF);
    send_op(OP_BLOCK, 6'd0, 32'd0);
    send_op(OP_FREE, 6'd63, 32'd0);
    send_op(OP_FIND, 6'd63, 32'd0);
    send_op(4'd15, 6'd42, 32'h5555_AAAA);
    gap(1);
    wait (pending == 0);

    // Fill the table, try once more, then drain it.
    for (int i = 0; i < 64; i++) send_op(OP_ALLOC, 6'd0, 32'd0);
    for (int i = 1; i < 64; i++) send_op(OP_FREE, 6'(i), 32'd0);
    gap(1);
    wait (pending == 0);

    // Random bursts separated by random gaps, some with no gap.
    for (int n = 0; n < 500; ) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) begin
        random_op();
        n++;
      end
      if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 30));
      if (n > 280 && n < 300) begin
        gap(1);
        wait (pending == 0);
      end
    end

    send_op(OP_FIND, ops[9] == OP_FIND ? 6'd0 : 6'd1, 32'd0);
    gap(1);
    wait (pending == 0);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog.
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
